// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned PRIO_W          = 16;
    localparam int unsigned KIND_W          = 2;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned OCC_W           = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  new_data;
        logic        [PRIO_W-1:0]  new_prio;
    } cell_cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts it toward a neighbor.
module spq_cell
(
    input  logic                                  clk,
    input  spq_pkg::cell_cmd_t                    cmd,
    input  logic                                  occupied,
    input  logic                                  left_lt,
    input  logic signed [spq_pkg::DATA_W-1:0]     left_data,
    input  logic        [spq_pkg::PRIO_W-1:0]     left_prio,
    input  logic signed [spq_pkg::DATA_W-1:0]     right_data,
    input  logic        [spq_pkg::PRIO_W-1:0]     right_prio,
    output logic signed [spq_pkg::DATA_W-1:0]     data,
    output logic        [spq_pkg::PRIO_W-1:0]     prio,
    output logic                                  lt
);

    logic signed [spq_pkg::DATA_W-1:0] data_reg;
    logic signed [spq_pkg::DATA_W-1:0] data_next;
    logic        [spq_pkg::PRIO_W-1:0] prio_reg;
    logic        [spq_pkg::PRIO_W-1:0] prio_next;

    // The stored entry is served ahead of the new one when its priority is smaller.
    assign lt   = occupied && (prio_reg < cmd.new_prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        case (cmd.op)
            spq_pkg::CELL_PUSH:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        data_next = cmd.new_data;
                        prio_next = cmd.new_prio;
                    end
                    else
                    begin
                        data_next = left_data;
                        prio_next = left_prio;
                    end
                end
            end
            spq_pkg::CELL_POP:
            begin
                data_next = right_data;
                prio_next = right_prio;
            end
            default:
            begin
                data_next = data_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: command decode, cell chain and result register.
//
//  Channel   Dir  tdata                                        tuser
//  s_axis    in   [31:0] item_data, [47:32] item_priority      [1:0] kind
//  m_axis    out  [31:0] result_data, [32] now_empty,          [1:0] status
//                 [37:33] occupancy, [39:38] zero
//
// All cells compare against the new priority in parallel and shift in the same edge, so a new
// word is taken each cycle while the output register is empty or its result is taken.
// The result appears in the output register in the cycle after its word is accepted.
// A stalled result holds the input off only while the output register is full.
// Reset empties the queue at once; the cell contents stay undefined until written.
module sorted_priority_queue
#(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_data, item_priority
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_data, now_empty, occupancy, zero pad
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                                accept;
    logic [spq_pkg::KIND_W-1:0]          kind;
    spq_pkg::cell_cmd_t                  cmd;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic [spq_pkg::STATUS_W-1:0]        status_next;
    logic signed [spq_pkg::DATA_W-1:0]   result_next;

    logic                                out_valid_reg;
    logic signed [spq_pkg::DATA_W-1:0]   result_reg;
    logic [spq_pkg::STATUS_W-1:0]        status_reg;
    logic                                empty_reg;
    logic [spq_pkg::OCC_W-1:0]           occ_reg;

    logic signed [spq_pkg::DATA_W-1:0]   cell_data [QUEUE_DEPTH];
    logic        [spq_pkg::PRIO_W-1:0]   cell_prio [QUEUE_DEPTH];
    logic        [QUEUE_DEPTH-1:0]       cell_lt;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = s_axis_tuser;

    always_comb
    begin
        cmd.op       = spq_pkg::CELL_HOLD;
        cmd.new_data = s_axis_tdata[31:0];
        cmd.new_prio = s_axis_tdata[47:32];
        count_next   = count_reg;
        status_next  = spq_pkg::STATUS_OK;
        result_next  = '0;
        case (kind)
            spq_pkg::KIND_PUSH:
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    status_next = spq_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.op     = accept ? spq_pkg::CELL_PUSH : spq_pkg::CELL_HOLD;
                    count_next = count_reg + 1'b1;
                end
            end
            spq_pkg::KIND_POP,
            spq_pkg::KIND_PEEK:
            begin
                if (count_reg == '0)
                begin
                    status_next = spq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    result_next = cell_data[0];
                    if (kind == spq_pkg::KIND_POP)
                    begin
                        cmd.op     = accept ? spq_pkg::CELL_POP : spq_pkg::CELL_HOLD;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = spq_pkg::STATUS_OK;
            end
        endcase
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                              occ;
        logic                              l_lt;
        logic signed [spq_pkg::DATA_W-1:0] l_data;
        logic        [spq_pkg::PRIO_W-1:0] l_prio;
        logic signed [spq_pkg::DATA_W-1:0] r_data;
        logic        [spq_pkg::PRIO_W-1:0] r_prio;

        assign occ = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign l_lt   = 1'b1;
            assign l_data = '0;
            assign l_prio = '0;
        end
        else
        begin : g_mid
            assign l_lt   = cell_lt[i-1];
            assign l_data = cell_data[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_data = '0;
            assign r_prio = '0;
        end
        else
        begin : g_inner
            assign r_data = cell_data[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (occ),
            .left_lt    (l_lt),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .right_data (r_data),
            .right_prio (r_prio),
            .data       (cell_data[i]),
            .prio       (cell_prio[i]),
            .lt         (cell_lt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
            empty_reg  <= (count_next == '0);
            occ_reg    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, occ_reg, empty_reg, result_reg};
    assign m_axis_tuser  = status_reg;

endmodule

// ----- tb/sorted_priority_queue_checker.sv -----
// Checker for the sorted priority queue: mirrors the queue, predicts each result and compares.
module sorted_priority_queue_checker
    import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_data, item_priority
    input  logic [1:0]  s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // result_data, now_empty, occupancy, zero pad
    input  logic [1:0]  m_axis_tuser,   // status
    output int          error_count,
    output int          pending_results,
    output int          checked_count,
    output int          full_count,
    output int          empty_count
);

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     now_empty;
        logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    logic signed [DATA_W-1:0] mirror_data [QUEUE_DEPTH];
    logic [PRIO_W-1:0]        mirror_prio [QUEUE_DEPTH];
    int unsigned              mirror_count;
    queue_result_t            awaited_results [$];
    queue_result_t            predicted;
    queue_result_t            observed;
    int                       mismatch_total;
    int                       checked_total;
    int                       full_total;
    int                       empty_total;

    assign error_count   = mismatch_total;
    assign checked_count = checked_total;
    assign full_count    = full_total;
    assign empty_count   = empty_total;

    function automatic queue_result_t service_request(
        input logic [KIND_W-1:0]      kind,
        input logic signed [DATA_W-1:0] data,
        input logic [PRIO_W-1:0]      prio
    );
        queue_result_t res;
        int unsigned   pos;
        int unsigned   i;
        res.data   = '0;
        res.status = STATUS_OK;
        if (kind == KIND_PUSH)
        begin
            if (mirror_count >= QUEUE_DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < mirror_count && mirror_prio[pos] < prio)
                begin
                    pos++;
                end
                for (i = mirror_count; i > pos; i--)
                begin
                    mirror_data[i] = mirror_data[i-1];
                    mirror_prio[i] = mirror_prio[i-1];
                end
                mirror_data[pos] = data;
                mirror_prio[pos] = prio;
                mirror_count++;
            end
        end
        else if (kind == KIND_POP || kind == KIND_PEEK)
        begin
            if (mirror_count == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                res.data = mirror_data[0];
                if (kind == KIND_POP)
                begin
                    for (i = 0; i + 1 < mirror_count; i++)
                    begin
                        mirror_data[i] = mirror_data[i+1];
                        mirror_prio[i] = mirror_prio[i+1];
                    end
                    mirror_count--;
                end
            end
        end
        res.now_empty = (mirror_count == 0);
        res.occupancy = OCC_W'(mirror_count);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_count = 0;
            awaited_results.delete();
            mismatch_total = 0;
            checked_total  = 0;
            full_total     = 0;
            empty_total    = 0;
            pending_results <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = service_request(s_axis_tuser, s_axis_tdata[31:0],
                                            s_axis_tdata[47:32]);
                if (predicted.status == STATUS_FULL)
                begin
                    full_total++;
                end
                if (predicted.status == STATUS_EMPTY)
                begin
                    empty_total++;
                end
                awaited_results.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed.data      = m_axis_tdata[31:0];
                observed.now_empty = m_axis_tdata[32];
                observed.occupancy = m_axis_tdata[37:33];
                observed.status    = m_axis_tuser;
                if (awaited_results.size() == 0)
                begin
                    mismatch_total++;
                    $display("%0t: result word with nothing expected, actual tdata 0x%0h tuser %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    predicted = awaited_results.pop_front();
                    checked_total++;
                    check_field("result_data", predicted.data, observed.data);
                    check_field("status", predicted.status, observed.status);
                    check_field("now_empty", predicted.now_empty, observed.now_empty);
                    check_field("occupancy", predicted.occupancy, observed.occupancy);
                end
            end
            pending_results <= awaited_results.size();
        end
    end

endmodule

// ----- tb/sorted_priority_queue_tb.sv -----
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int unsigned       DEPTH        = QUEUE_DEPTH_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam int                CLK_PERIOD   = 12;
    localparam int                IDLE_PCT     = 11;
    localparam int                HOLD_CYCLES  = 80;
    localparam int                DRAIN_CYCLES = 5;
    localparam int                NOISE_PCT    = 3;

    typedef enum {
        PRIO_ANY,
        PRIO_NARROW,
        PRIO_EXTREME
    } prio_mix_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // item_data, item_priority
    logic [1:0]  s_axis_tuser  = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // result_data, now_empty, occupancy, zero pad
    logic [1:0]  m_axis_tuser;         // status

    int error_count;
    int pending_results;
    int checked_count;
    int full_count;
    int empty_count;
    int kind_tally [4];
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;

    sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_priority_queue_checker #(.QUEUE_DEPTH(DEPTH)) queue_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .error_count     (error_count),
        .pending_results (pending_results),
        .checked_count   (checked_count),
        .full_count      (full_count),
        .empty_count     (empty_count)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("Timeout with %0d result words still outstanding", pending_results);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The receiver counts out a long hold-off on request, otherwise it stalls at random while gaps are on.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    function automatic logic [PRIO_W-1:0] pick_prio(input prio_mix_t mix);
        case (mix)
            PRIO_NARROW:
                return PRIO_W'($urandom_range(3));
            PRIO_EXTREME:
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 16'h8000;
                    default: return PRIO_W'($urandom);
                endcase
            default:
                return PRIO_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] data,
                             input logic [PRIO_W-1:0] prio);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, data};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        kind_tally[kind]++;
    endtask

    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int words, input int push_pct, input prio_mix_t mix);
        int done;
        int roll;
        done = 0;
        while (done < words)
        begin
            roll = $urandom_range(99);
            if (roll < NOISE_PCT)
            begin
                send_word(KIND_UNUSED, $urandom, pick_prio(mix));
            end
            else
            begin
                done++;
                if ($urandom_range(99) < push_pct)
                begin
                    send_word(KIND_PUSH, $urandom, pick_prio(mix));
                end
                else if ($urandom_range(99) < 70)
                begin
                    send_word(KIND_POP, $urandom, pick_prio(mix));
                end
                else
                begin
                    send_word(KIND_PEEK, $urandom, pick_prio(mix));
                end
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_POP, 32'h0, 16'h0);
        send_word(KIND_PEEK, 32'h0, 16'h0);
        send_word(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(KIND_PUSH, 32'h8000_0000, 16'hFFFF);
        send_word(KIND_PUSH, 32'h7FFF_FFFF, 16'h0000);
        send_word(KIND_PUSH, 32'hFFFF_FFFF, 16'h5555);
        send_word(KIND_PUSH, 32'h0000_0000, 16'h5555);
        send_word(KIND_PUSH, 32'h1234_5678, 16'h5555);
        send_word(KIND_PUSH, 32'hAAAA_AAAA, 16'h0000);
        send_word(KIND_PEEK, 32'hDEAD_BEEF, 16'h1111);
        send_word(KIND_UNUSED, 32'h0, 16'h0);
        repeat (7)
        begin
            send_word(KIND_POP, 32'h5A5A_5A5A, 16'hA5A5);
        end

        run_phase(150, 55, PRIO_ANY);
        hold_request = 1'b1;
        run_phase(100, 85, PRIO_EXTREME);
        wait_for_results();
        run_phase(120, 20, PRIO_ANY);
        gaps_on = 1'b0;
        run_phase(150, 60, PRIO_NARROW);
        gaps_on = 1'b1;
        run_phase(180, 50, PRIO_EXTREME);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d push, %0d pop, %0d peek and %0d unused-code words.",
                 kind_tally[KIND_PUSH], kind_tally[KIND_POP], kind_tally[KIND_PEEK],
                 kind_tally[KIND_UNUSED]);
        $display("Checked %0d results, including %0d pushes to a full queue and %0d reads of an empty one.",
                 checked_count, full_count, empty_count);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
